// ===== hw/rtl/mspfe_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the MSP v1 request framer.
// No dependencies; used by every module of the block.
package mspfe_pkg;

  localparam logic [7:0] SYNC_DOLLAR = 8'h24;  // '$'
  localparam logic [7:0] SYNC_M      = 8'h4D;  // 'M'
  localparam logic [7:0] DIR_REQUEST = 8'h3C;  // '<'

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [7:0] command;
    logic [7:0] payload_length;
    logic [7:0] data_byte;
  } req_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_end;
  } tx_item_t;

  // One classified transaction, as handed from the front to the back.
  typedef struct packed {
    logic       start;      // emit the five header bytes first
    logic [7:0] len;
    logic [7:0] cmd;
    logic [7:0] dat;
    logic       has_data;   // emit dat
    logic       has_check;  // emit check and close the frame
    logic [7:0] check;
  } job_t;

  // Queue handshake between front and back.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // Byte position within a frame.
  typedef enum logic [2:0] {
    POS_DOLLAR,
    POS_M,
    POS_DIR,
    POS_LEN,
    POS_CMD,
    POS_DATA,
    POS_CHECK
  } pos_t;

endpackage

// ===== hw/rtl/mspfe_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts request transactions, tracks frame position and checksum,
// and produces one job per transaction. Depends on mspfe_pkg.
module mspfe_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  mspfe_pkg::req_item_t req,
  input  mspfe_pkg::queue_status_t qstat,
  output logic                push,
  output mspfe_pkg::job_t     job
);

  logic [7:0] bytes_left;
  logic [7:0] bytes_left_next;
  logic [7:0] running_check;
  logic [7:0] running_check_next;
  logic [7:0] chk_hdr;
  logic [7:0] chk_dat;

  assign req_stall = qstat.full;
  assign push      = req_valid && !qstat.full;

  always_comb begin
    chk_hdr            = req.payload_length ^ req.command;
    chk_dat            = 8'h00;
    job                = '0;
    job.len            = req.payload_length;
    job.cmd            = req.command;
    job.dat            = req.data_byte;
    bytes_left_next    = bytes_left;
    running_check_next = running_check;
    if (bytes_left == 8'd0) begin
      job.start = 1'b1;
      if (req.payload_length == 8'd0) begin
        job.has_data       = 1'b0;
        job.has_check      = 1'b1;
        job.check          = chk_hdr;
        bytes_left_next    = 8'd0;
        running_check_next = 8'h00;
      end else begin
        chk_dat            = chk_hdr ^ req.data_byte;
        job.has_data       = 1'b1;
        job.has_check      = (req.payload_length == 8'd1);
        job.check          = chk_dat;
        bytes_left_next    = req.payload_length - 8'd1;
        running_check_next = job.has_check ? 8'h00 : chk_dat;
      end
    end else begin
      chk_dat            = running_check ^ req.data_byte;
      job.start          = 1'b0;
      job.has_data       = 1'b1;
      job.has_check      = (bytes_left == 8'd1);
      job.check          = chk_dat;
      bytes_left_next    = bytes_left - 8'd1;
      running_check_next = job.has_check ? 8'h00 : chk_dat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left    <= 8'd0;
      running_check <= 8'h00;
    end else if (push) begin
      bytes_left    <= bytes_left_next;
      running_check <= running_check_next;
    end
  end

endmodule

// ===== hw/rtl/mspfe_queue.sv =====
`timescale 1ns / 1ps
// Small first-word-fall-through job queue between front and back.
// Depends on mspfe_pkg.
module mspfe_queue (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  mspfe_pkg::job_t          push_job,
  input  logic                     pop,
  output mspfe_pkg::job_t          head,
  output mspfe_pkg::queue_status_t qstat
);

  mspfe_pkg::job_t                 mem [mspfe_pkg::QUEUE_DEPTH];
  logic [mspfe_pkg::QUEUE_AW-1:0]  wr_ptr;
  logic [mspfe_pkg::QUEUE_AW-1:0]  rd_ptr;
  logic [mspfe_pkg::QUEUE_AW:0]    count;

  assign head        = mem[rd_ptr];
  assign qstat.full  = (count == (mspfe_pkg::QUEUE_AW+1)'(mspfe_pkg::QUEUE_DEPTH));
  assign qstat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hw/rtl/mspfe_back.sv =====
`timescale 1ns / 1ps
// Back end: walks each queued job through its frame bytes, one byte per
// cycle unless tx is stalled, into the output register. Depends on mspfe_pkg.
module mspfe_back (
  input  logic                     clk,
  input  logic                     rst,
  input  mspfe_pkg::job_t          head,
  input  mspfe_pkg::queue_status_t qstat,
  output logic                     pop,
  output logic                     tx_valid,
  input  logic                     tx_stall,
  output mspfe_pkg::tx_item_t      tx
);

  mspfe_pkg::pos_t     pos;
  mspfe_pkg::pos_t     pos_next;
  mspfe_pkg::pos_t     cur;
  logic                started;
  logic                advance;
  logic                last;
  mspfe_pkg::tx_item_t tx_next;

  assign advance = !qstat.empty && (!tx_valid || !tx_stall);
  assign pop     = advance && last;

  always_comb begin
    if (started) begin
      cur = pos;
    end else begin
      cur = head.start ? mspfe_pkg::POS_DOLLAR : mspfe_pkg::POS_DATA;
    end
    tx_next  = '0;
    last     = 1'b0;
    pos_next = cur;
    unique case (cur)
      mspfe_pkg::POS_DOLLAR: begin
        tx_next.out_byte = mspfe_pkg::SYNC_DOLLAR;
        pos_next         = mspfe_pkg::POS_M;
      end
      mspfe_pkg::POS_M: begin
        tx_next.out_byte = mspfe_pkg::SYNC_M;
        pos_next         = mspfe_pkg::POS_DIR;
      end
      mspfe_pkg::POS_DIR: begin
        tx_next.out_byte = mspfe_pkg::DIR_REQUEST;
        pos_next         = mspfe_pkg::POS_LEN;
      end
      mspfe_pkg::POS_LEN: begin
        tx_next.out_byte = head.len;
        pos_next         = mspfe_pkg::POS_CMD;
      end
      mspfe_pkg::POS_CMD: begin
        tx_next.out_byte = head.cmd;
        pos_next         = head.has_data ? mspfe_pkg::POS_DATA : mspfe_pkg::POS_CHECK;
      end
      mspfe_pkg::POS_DATA: begin
        tx_next.out_byte = head.dat;
        last             = !head.has_check;
        pos_next         = mspfe_pkg::POS_CHECK;
      end
      mspfe_pkg::POS_CHECK: begin
        tx_next.out_byte  = head.check;
        tx_next.frame_end = 1'b1;
        last              = 1'b1;
        pos_next          = mspfe_pkg::POS_DOLLAR;
      end
      default: begin
        tx_next.out_byte = head.check;
        last             = 1'b1;
        pos_next         = mspfe_pkg::POS_DOLLAR;
      end
    endcase
    tx_next.run_last = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= mspfe_pkg::POS_DOLLAR;
      started <= 1'b0;
    end else if (advance) begin
      pos     <= pos_next;
      started <= !last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_valid <= 1'b0;
    end else if (advance) begin
      tx_valid <= 1'b1;
    end else if (!tx_stall) begin
      tx_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      tx <= tx_next;
    end
  end

endmodule

// ===== hw/rtl/msp_v1_frame_encoder.sv =====
`timescale 1ns / 1ps
// MSP v1 request framer, top level.
// Depends on mspfe_pkg, mspfe_front, mspfe_queue and mspfe_back.
// Usage:
//   req channel (req_valid / req_stall / req): one transaction per payload
//   byte. At frame start it carries command, payload_length and the first
//   data byte; mid-frame only data_byte is used. A zero-length frame takes
//   one transaction whose data_byte is ignored.
//   tx channel (tx_valid / tx_stall / tx): the frame as a byte stream:
//   '$','M','<', length, command, payload bytes, XOR checksum. run_last
//   marks the final byte caused by a req transaction, frame_end the checksum.
// Timing:
//   With the queue empty, an accepted transaction is written into the job queue,
//   and its first byte is then registered into tx from the queue head.
//   The back end emits one byte per cycle unless tx is stalled; a frame-start
//   transaction yields 6 or 7 bytes and a mid-frame one 1 or 2 bytes.
//   A 4-entry job queue lets the front keep accepting one transaction per
//   cycle while the back works through headers; req_stall rises only when
//   that queue is full. Reset clears frame position, checksum, queue and
//   tx_valid. While tx_stall is high tx holds and the queue absorbs requests.
module msp_v1_frame_encoder (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  mspfe_pkg::req_item_t req,
  output logic                 tx_valid,
  input  logic                 tx_stall,
  output mspfe_pkg::tx_item_t  tx
);

  mspfe_pkg::queue_status_t qstat;
  mspfe_pkg::job_t          push_job;
  mspfe_pkg::job_t          head;
  logic                     push;
  logic                     pop;

  // Classifies each transaction and tracks bytes_left / running checksum.
  mspfe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .qstat     (qstat),
    .push      (push),
    .job       (push_job)
  );

  // Decouples accept rate from the multi-byte header expansion.
  mspfe_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .qstat    (qstat)
  );

  // Serializes each job, one byte per cycle unless tx is stalled, into the output register.
  mspfe_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .qstat    (qstat),
    .pop      (pop),
    .tx_valid (tx_valid),
    .tx_stall (tx_stall),
    .tx       (tx)
  );

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for msp_v1_frame_encoder: frame-level stimulus, byte checks.
// Depends on mspfe_pkg (req_item_t, tx_item_t) and the msp_v1_frame_encoder RTL.
module testbench;

  // Frame sync and direction bytes, kept local so a wrong package constant shows up.
  localparam logic [7:0] HDR_DOLLAR  = 8'h24;
  localparam logic [7:0] HDR_M       = 8'h4D;
  localparam logic [7:0] HDR_REQUEST = 8'h3C;

  localparam int QUIET_LIMIT = 2000;  // cycles with no transaction on either side
  localparam int SETTLE      = 8;     // margin after the scoreboard has emptied
  localparam int PHASE_ITEMS = 50;    // random request transactions per idle profile

  // Predicts the tx byte stream from accepted requests and checks it, byte by byte.
  class frame_scoreboard;
    logic [7:0]          bytes_left;
    logic [7:0]          xor_sum;
    mspfe_pkg::tx_item_t pending_bytes[$];
    int                  mismatches;
    int                  bytes_checked;

    function new();
      bytes_left    = '0;
      xor_sum       = '0;
      mismatches    = 0;
      bytes_checked = 0;
    endfunction

    function void push_byte(logic [7:0] b, logic is_check);
      mspfe_pkg::tx_item_t t;
      t.out_byte  = b;
      t.run_last  = 1'b0;
      t.frame_end = is_check;
      pending_bytes.push_back(t);
    endfunction

    function void note_request(mspfe_pkg::req_item_t item);
      mspfe_pkg::tx_item_t t;
      if (bytes_left == 0) begin
        push_byte(HDR_DOLLAR, 1'b0);
        push_byte(HDR_M, 1'b0);
        push_byte(HDR_REQUEST, 1'b0);
        push_byte(item.payload_length, 1'b0);
        push_byte(item.command, 1'b0);
        xor_sum    = item.payload_length ^ item.command;
        bytes_left = item.payload_length;
      end
      // zero-length frame skips straight to the checksum
      if (bytes_left != 0) begin
        push_byte(item.data_byte, 1'b0);
        xor_sum    = xor_sum ^ item.data_byte;
        bytes_left = bytes_left - 8'd1;
        if (bytes_left == 0) begin
          push_byte(xor_sum, 1'b1);
          xor_sum = '0;
        end
      end else begin
        push_byte(xor_sum, 1'b1);
        xor_sum = '0;
      end
      t = pending_bytes.pop_back();
      t.run_last = 1'b1;
      pending_bytes.push_back(t);
    endfunction

    function void check_tx(mspfe_pkg::tx_item_t got);
      mspfe_pkg::tx_item_t want;
      bytes_checked++;
      if (pending_bytes.size() == 0) begin
        $error("unexpected tx transaction: out_byte %02h run_last %0b frame_end %0b",
               got.out_byte, got.run_last, got.frame_end);
        mismatches++;
      end else begin
        want = pending_bytes.pop_front();
        if (got.out_byte !== want.out_byte) begin
          $error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
          mismatches++;
        end
        if (got.run_last !== want.run_last) begin
          $error("run_last: expected %0b, got %0b", want.run_last, got.run_last);
          mismatches++;
        end
        if (got.frame_end !== want.frame_end) begin
          $error("frame_end: expected %0b, got %0b", want.frame_end, got.frame_end);
          mismatches++;
        end
      end
    endfunction
  endclass

  // All block inputs start at known values; reset is high from time zero.
  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 req_valid = 1'b0;
  logic                 req_stall;
  mspfe_pkg::req_item_t req       = '0;
  logic                 tx_valid;
  logic                 tx_stall  = 1'b0;
  mspfe_pkg::tx_item_t  tx;

  frame_scoreboard sb;

  int unsigned send_idle_pct = 0;  // chance of an idle cycle before each request
  int unsigned stall_pct     = 0;  // chance of tx_stall in a given cycle
  int          items_sent    = 0;
  int          frames_sent   = 0;
  int          quiet_cycles  = 0;

  msp_v1_frame_encoder dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .tx_valid  (tx_valid),
    .tx_stall  (tx_stall),
    .tx        (tx)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // One request transaction. Idle cycles come first; valid is only lowered on a
  // cycle that really idles, so back-to-back requests keep it high.
  task automatic send_item(input logic [7:0] cmd, input logic [7:0] len,
                           input logic [7:0] dat);
    mspfe_pkg::req_item_t item;
    item.command        = cmd;
    item.payload_length = len;
    item.data_byte      = dat;
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sb.note_request(item);
    items_sent++;
  endtask

  // Whole frame with random payload; mid-frame command/length are random junk
  // that the block must ignore.
  task automatic send_frame(input logic [7:0] cmd, input logic [7:0] len);
    send_item(cmd, len, 8'($urandom_range(255)));
    for (int i = 1; i < len; i++) begin
      send_item(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)));
    end
    frames_sent++;
  endtask

  // Sender holds off until every predicted byte has come out.
  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // tx side: check every accepted byte, randomize the stall for the next cycle,
  // and track how long nothing has moved on either channel.
  always @(posedge clk) begin
    if (rst) begin
      tx_stall     <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      if (tx_valid && !tx_stall) begin
        sb.check_tx(tx);
      end
      if ((tx_valid && !tx_stall) || (req_valid && !req_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      tx_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog: a hung handshake ends the run.
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("timeout: no transaction for %0d cycles, %0d bytes still expected",
             QUIET_LIMIT, sb.pending_bytes.size());
    $display("[msp_v1_frame_encoder] ERROR");
    $finish;
  end

  initial begin
    int          phase_start;
    logic [7:0]  len;
    int unsigned r;
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: zero-length frames (data byte ignored) at command extremes
    send_item(8'h00, 8'h00, 8'hFF);
    send_item(8'hFF, 8'h00, 8'h00);
    // one-byte frames: header, payload and checksum from a single transaction
    send_item(8'hA5, 8'h01, 8'h5A);
    send_item(8'hFF, 8'h01, 8'hFF);
    // two-byte frame; mid-frame command/length at all-ones must be ignored
    send_item(8'h00, 8'h02, 8'h00);
    send_item(8'hFF, 8'hFF, 8'hFF);
    // three-byte frame with the sender parked mid-frame until the tx side is empty
    send_item(8'h5A, 8'h03, 8'hC3);
    drain();
    send_item(8'h00, 8'h00, 8'h81);
    send_item(8'hFF, 8'h80, 8'h7E);
    frames_sent += 6;
    drain();

    // Random frames under four idle profiles; the last one also carries a
    // maximum-length frame so every payload byte position is hit with gaps.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 60;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 60;
        end
        default: begin
          send_idle_pct = 13;
          stall_pct     = 13;
        end
      endcase
      phase_start = items_sent;
      if (phase == 3) begin
        send_frame(8'($urandom_range(255)), 8'hFF);
        phase_start = items_sent;
      end
      while (items_sent - phase_start < PHASE_ITEMS) begin
        // mostly short frames; some zero/one-byte, a few longer
        r = $urandom_range(99);
        if (r < 15) len = 8'd0;
        else if (r < 35) len = 8'd1;
        else if (r < 90) len = 8'($urandom_range(8, 2));
        else len = 8'($urandom_range(40, 9));
        send_frame(8'($urandom_range(255)), len);
      end
      drain();
    end

    // Let any stray output show up as an unexpected transaction.
    stall_pct = 0;
    repeat (20) @(posedge clk);

    $display("covered %0d frames from %0d request transactions, %0d tx bytes checked",
             frames_sent, items_sent, sb.bytes_checked);
    $display("idle profiles: none, sender 60%%, receiver 60%%, both 13%%; payloads 0..255");
    if (sb.mismatches == 0 && sb.pending_bytes.size() == 0) begin
      $display("[msp_v1_frame_encoder] OK");
    end else begin
      $display("[msp_v1_frame_encoder] ERROR");
    end
    $finish;
  end

endmodule
